>>> hw/rtl/bscs_pkg.sv
// Package for the brake system initial check sequencer.
// Holds the state encoding, command bits, status codes and the poll and result types.
// Depends on nothing.
package bscs_pkg;

  localparam int unsigned SettleWidth    = 16;
  localparam int unsigned TimeWidth      = 32;
  localparam int unsigned CmdWidth       = 13;
  localparam logic [SettleWidth-1:0] SettleReset = 16'd100;

  typedef enum logic [4:0] {
    ST_WAIT_MISSION   = 5'd0,
    ST_WAIT_ASMS      = 5'd1,
    ST_ARM_EBS        = 5'd2,
    ST_WAIT_RES       = 5'd3,
    ST_CLOSE_SDC      = 5'd4,
    ST_WAIT_SDC_CLOSE = 5'd5,
    ST_STOP_WDG       = 5'd6,
    ST_WAIT_SDC_OPEN  = 5'd7,
    ST_START_WDG      = 5'd8,
    ST_WAIT_SDC_AGAIN = 5'd9,
    ST_WAIT_TSMS      = 5'd10,
    ST_RELEASE_EBS    = 5'd11,
    ST_ENGAGE_SYS1    = 5'd12,
    ST_RELEASE_SYS1   = 5'd13,
    ST_ENGAGE_SYS2    = 5'd14,
    ST_RELEASE_SYS2   = 5'd15,
    ST_ENGAGE_SVC     = 5'd16,
    ST_RELEASE_SVC    = 5'd17,
    ST_PARK_SVC       = 5'd18,
    ST_NOTIFY_APU     = 5'd19,
    ST_COMPLETE       = 5'd20
  } bscs_state_t;

  localparam logic [CmdWidth-1:0] CMD_EBS_ARM     = 13'h0001;
  localparam logic [CmdWidth-1:0] CMD_EBS_RELEASE = 13'h0002;
  localparam logic [CmdWidth-1:0] CMD_SYS1_ON     = 13'h0004;
  localparam logic [CmdWidth-1:0] CMD_SYS1_OFF    = 13'h0008;
  localparam logic [CmdWidth-1:0] CMD_SYS2_ON     = 13'h0010;
  localparam logic [CmdWidth-1:0] CMD_SYS2_OFF    = 13'h0020;
  localparam logic [CmdWidth-1:0] CMD_SVC_ENGAGE  = 13'h0040;
  localparam logic [CmdWidth-1:0] CMD_SVC_DISENG  = 13'h0080;
  localparam logic [CmdWidth-1:0] CMD_SVC_PARK    = 13'h0100;
  localparam logic [CmdWidth-1:0] CMD_SDC_CLOSE   = 13'h0200;
  localparam logic [CmdWidth-1:0] CMD_SDC_OPEN    = 13'h0400;
  localparam logic [CmdWidth-1:0] CMD_WDG_STOP    = 13'h0800;
  localparam logic [CmdWidth-1:0] CMD_WDG_START   = 13'h1000;

  localparam logic [1:0] SVC_DISENGAGED = 2'd0;
  localparam logic [1:0] SVC_ENGAGED    = 2'd1;
  localparam logic [1:0] PRES_ENGAGED   = 2'd1;
  localparam logic [1:0] PRES_RELEASED  = 2'd2;
  localparam logic [3:0] APU_READY      = 4'd2;

  typedef struct packed {
    logic                 auto_mission;
    logic                 asms_on;
    logic                 tsms_on;
    logic                 relay_in;
    logic                 relay_out;
    logic                 ebs_active;
    logic                 system1_on;
    logic                 system2_on;
    logic [1:0]           service_status;
    logic [1:0]           pressure_level;
    logic [3:0]           apu_state;
    logic [TimeWidth-1:0] now_ms;
  } bscs_poll_t;

  typedef struct packed {
    logic [4:0]          check_state;
    logic [CmdWidth-1:0] command_mask;
    logic                failed;
    logic                notify_apu;
    logic                complete;
  } bscs_result_t;

endpackage

>>> hw/rtl/brake_system_initial_check_sequencer.sv
// Top level of the brake system initial check sequencer.
// Instantiates bscs_in_stage, bscs_core and bscs_out_stage; depends on bscs_pkg.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+------------------------------
//   poll     | in        | poll_valid / poll_ready      | switch, relay, brake, APU, time
//   result   | out       | result_valid / result_ready  | state, commands, flags
//   config   | in        | cfg_write_en (no wait)       | cfg_write_data = settle time
//
// One poll item is taken per clock cycle when the result side keeps up.
// An item waits in the input register while the step logic works on it; the edge on
// which the result register can take the result updates the check state and settle
// timer and loads the result register, which then shows the result item.
// Reset (synchronous, active high) returns the sequence to wait-for-mission, stops the
// settle timer and sets the settle time back to 100 ms.
// While a result is stalled the input register still takes one more item, after which
// poll_ready drops until the result is taken.
module brake_system_initial_check_sequencer import bscs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [SettleWidth-1:0] cfg_write_data,
  input  logic                   poll_valid,
  output logic                   poll_ready,
  input  logic                   auto_mission,
  input  logic                   asms_on,
  input  logic                   tsms_on,
  input  logic                   relay_in,
  input  logic                   relay_out,
  input  logic                   ebs_active,
  input  logic                   system1_on,
  input  logic                   system2_on,
  input  logic [1:0]             service_status,
  input  logic [1:0]             pressure_level,
  input  logic [3:0]             apu_state,
  input  logic [TimeWidth-1:0]   now_ms,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [4:0]             check_state,
  output logic [CmdWidth-1:0]    command_mask,
  output logic                   failed,
  output logic                   notify_apu,
  output logic                   complete
);

  logic [SettleWidth-1:0] settle_time_ms;
  bscs_poll_t             poll_in, held;
  bscs_result_t           step_result, result;
  logic                   held_valid, can_load, take;

  // The user must write the settle time register only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_time_ms <= SettleReset;
    end else if (cfg_write_en) begin
      settle_time_ms <= cfg_write_data;
    end
  end

  always_comb begin
    poll_in.auto_mission   = auto_mission;
    poll_in.asms_on        = asms_on;
    poll_in.tsms_on        = tsms_on;
    poll_in.relay_in       = relay_in;
    poll_in.relay_out      = relay_out;
    poll_in.ebs_active     = ebs_active;
    poll_in.system1_on     = system1_on;
    poll_in.system2_on     = system2_on;
    poll_in.service_status = service_status;
    poll_in.pressure_level = pressure_level;
    poll_in.apu_state      = apu_state;
    poll_in.now_ms         = now_ms;
  end

  // The held item is stepped only when the result register can take its result.
  assign take = held_valid && can_load;

  bscs_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .poll_valid (poll_valid),
    .poll_ready (poll_ready),
    .poll_in    (poll_in),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  bscs_core u_core (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .poll           (held),
    .settle_time_ms (settle_time_ms),
    .result         (step_result)
  );

  bscs_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load         (take),
    .result_in    (step_result),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assign check_state  = result.check_state;
  assign command_mask = result.command_mask;
  assign failed       = result.failed;
  assign notify_apu   = result.notify_apu;
  assign complete     = result.complete;

endmodule

>>> hw/rtl/bscs_in_stage.sv
// Input register of the sequencer: captures one poll item and holds it until the core takes it.
// Depends on bscs_pkg.
module bscs_in_stage import bscs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       poll_valid,
  output logic       poll_ready,
  input  bscs_poll_t poll_in,
  input  logic       take,
  output logic       held_valid,
  output bscs_poll_t held
);

  assign poll_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (poll_ready) begin
      held_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_valid && poll_ready) begin
      held <= poll_in;
    end
  end

endmodule

>>> hw/rtl/bscs_core.sv
// Sequencer core: check state, settle timer and the one-poll step logic.
// Depends on bscs_pkg.
module bscs_core import bscs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  bscs_poll_t             poll,
  input  logic [SettleWidth-1:0] settle_time_ms,
  output bscs_result_t           result
);

  bscs_state_t          seq_state, seq_state_next, base_state;
  logic [TimeWidth-1:0] timer_start, timer_start_next, elapsed;
  logic                 timer_running, timer_running_next;
  logic                 fail, timed, settled;
  logic [CmdWidth-1:0]  cmd;
  logic [4:0]           s_code;

  assign s_code = seq_state;

  // Safety checks that depend on the current state.
  always_comb begin
    fail = 1'b0;
    if (s_code > ST_WAIT_MISSION && s_code < ST_COMPLETE) begin
      priority if (!poll.asms_on || !poll.auto_mission) begin
        fail = 1'b1;
      end else if (s_code > ST_WAIT_TSMS) begin
        fail = !poll.tsms_on;
      end else if (s_code == ST_WAIT_TSMS) begin
        fail = !poll.relay_out;
      end else if (s_code > ST_WAIT_RES) begin
        fail = !poll.relay_in;
      end else begin
        fail = 1'b0;
      end
    end
    base_state = fail ? ST_WAIT_MISSION : seq_state;
  end

  // Settle timer: a stopped timer restarts at the current time.
  always_comb begin
    timed = (base_state >= ST_RELEASE_EBS) && (base_state <= ST_RELEASE_SVC);
    timer_start_next = timer_running ? timer_start : poll.now_ms;
    elapsed = poll.now_ms - timer_start_next;
    settled = elapsed >= {{(TimeWidth-SettleWidth){1'b0}}, settle_time_ms};
    timer_running_next = timed ? !settled : timer_running;
  end

  always_comb begin
    seq_state_next = base_state;
    cmd = fail ? (CMD_EBS_ARM | CMD_SDC_OPEN) : '0;
    unique case (base_state)
      ST_WAIT_MISSION:   if (poll.auto_mission) seq_state_next = ST_WAIT_ASMS;
      ST_WAIT_ASMS:      if (poll.asms_on) seq_state_next = ST_ARM_EBS;
      ST_ARM_EBS: begin
        cmd = cmd | CMD_EBS_ARM;
        seq_state_next = ST_WAIT_RES;
      end
      ST_WAIT_RES:       if (poll.relay_in) seq_state_next = ST_CLOSE_SDC;
      ST_CLOSE_SDC: begin
        cmd = cmd | CMD_SDC_CLOSE;
        seq_state_next = ST_WAIT_SDC_CLOSE;
      end
      ST_WAIT_SDC_CLOSE: if (poll.relay_out) seq_state_next = ST_STOP_WDG;
      ST_STOP_WDG: begin
        cmd = cmd | CMD_WDG_STOP;
        seq_state_next = ST_WAIT_SDC_OPEN;
      end
      ST_WAIT_SDC_OPEN:  if (!poll.relay_out) seq_state_next = ST_START_WDG;
      ST_START_WDG: begin
        cmd = cmd | CMD_WDG_START;
        seq_state_next = ST_WAIT_SDC_AGAIN;
      end
      ST_WAIT_SDC_AGAIN: if (poll.relay_out) seq_state_next = ST_WAIT_TSMS;
      ST_WAIT_TSMS:      if (poll.tsms_on) seq_state_next = ST_RELEASE_EBS;
      ST_RELEASE_EBS: begin
        if (poll.ebs_active) cmd = cmd | CMD_EBS_RELEASE | CMD_SVC_DISENG;
        if (settled && poll.pressure_level == PRES_RELEASED) seq_state_next = ST_ENGAGE_SYS1;
      end
      ST_ENGAGE_SYS1: begin
        if (!poll.system1_on) cmd = cmd | CMD_SYS1_ON;
        if (settled && poll.pressure_level == PRES_ENGAGED) seq_state_next = ST_RELEASE_SYS1;
      end
      ST_RELEASE_SYS1: begin
        if (poll.system1_on) cmd = cmd | CMD_SYS1_OFF;
        if (settled && poll.pressure_level == PRES_RELEASED) seq_state_next = ST_ENGAGE_SYS2;
      end
      ST_ENGAGE_SYS2: begin
        if (!poll.system2_on) cmd = cmd | CMD_SYS2_ON;
        if (settled && poll.pressure_level == PRES_ENGAGED) seq_state_next = ST_RELEASE_SYS2;
      end
      ST_RELEASE_SYS2: begin
        if (poll.system2_on) cmd = cmd | CMD_SYS2_OFF;
        if (settled && poll.pressure_level == PRES_RELEASED) seq_state_next = ST_ENGAGE_SVC;
      end
      ST_ENGAGE_SVC: begin
        if (poll.service_status != SVC_ENGAGED) cmd = cmd | CMD_SVC_ENGAGE;
        if (settled && poll.pressure_level == PRES_ENGAGED) seq_state_next = ST_RELEASE_SVC;
      end
      ST_RELEASE_SVC: begin
        if (poll.service_status != SVC_DISENGAGED) cmd = cmd | CMD_SVC_DISENG;
        if (settled && poll.pressure_level == PRES_RELEASED) seq_state_next = ST_PARK_SVC;
      end
      ST_PARK_SVC: begin
        cmd = cmd | CMD_SVC_PARK;
        seq_state_next = ST_NOTIFY_APU;
      end
      ST_NOTIFY_APU:     if (poll.apu_state == APU_READY) seq_state_next = ST_COMPLETE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state     <= ST_WAIT_MISSION;
      timer_start   <= '0;
      timer_running <= 1'b0;
    end else if (take) begin
      seq_state <= seq_state_next;
      if (timed) begin
        timer_start   <= timer_start_next;
        timer_running <= timer_running_next;
      end
    end
  end

  always_comb begin
    result.check_state  = seq_state_next;
    result.command_mask = cmd;
    result.failed       = fail;
    result.notify_apu   = (seq_state_next == ST_NOTIFY_APU);
    result.complete     = (seq_state_next == ST_COMPLETE);
  end

endmodule

>>> hw/rtl/bscs_out_stage.sv
// Result register of the sequencer: holds one result item until the consumer takes it.
// Depends on bscs_pkg.
module bscs_out_stage import bscs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  bscs_result_t result_in,
  output logic         can_load,
  output logic         result_valid,
  input  logic         result_ready,
  output bscs_result_t result
);

  assign can_load = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_load) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

>>> hw/rtl/bscs_checker.sv
// Port-level checks for the brake system initial check sequencer, bound to the top level.
// Depends on bscs_pkg and brake_system_initial_check_sequencer.
module bscs_checker import bscs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input logic [4:0]          check_state,
  input logic [CmdWidth-1:0] command_mask,
  input logic                failed,
  input logic                notify_apu,
  input logic                complete
);

  // No result item appears in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result item holds its state field.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(check_state))
    else $error("stalled result changed");

  // A failure arms the EBS, opens the circuit and leaves the sequence in wait-for-mission or wait-ASMS.
  a_fail_cmd: assert property (@(posedge clk) disable iff (rst)
    result_valid && failed |-> (command_mask & (CMD_EBS_ARM | CMD_SDC_OPEN))
      == (CMD_EBS_ARM | CMD_SDC_OPEN)
      && (check_state == ST_WAIT_MISSION || check_state == ST_WAIT_ASMS))
    else $error("failure without safe commands");

  // The status flags follow the reported state.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> notify_apu == (check_state == ST_NOTIFY_APU)
      && complete == (check_state == ST_COMPLETE))
    else $error("status flags disagree with state");

endmodule

bind brake_system_initial_check_sequencer bscs_checker u_bscs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .check_state  (check_state),
  .command_mask (command_mask),
  .failed       (failed),
  .notify_apu   (notify_apu),
  .complete     (complete)
);

>>> sim/bscs_step_checker.sv
// Scoreboard for the brake system initial check sequencer testbench.
// Watches the poll, result and configuration ports, predicts each result and compares.
// Depends on bscs_pkg.
`timescale 1ns / 100ps

module bscs_step_checker import bscs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [SettleWidth-1:0] cfg_write_data,
  input  logic                   poll_valid,
  input  logic                   poll_ready,
  input  bscs_poll_t             poll,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  logic [4:0]             check_state,
  input  logic [CmdWidth-1:0]    command_mask,
  input  logic                   failed,
  input  logic                   notify_apu,
  input  logic                   complete,
  output int unsigned            pending,
  output int unsigned            fail_count,
  output logic [4:0]             model_state
);

  logic [SettleWidth-1:0] settle_ms;
  logic [4:0]             seq_q;
  logic [TimeWidth-1:0]   timer_start_q;
  logic                   timer_run_q;
  bscs_result_t           predicted_steps[$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    fail_count++;
  endtask

  // One poll of the self-test: safety checks first, then at most one state step.
  function automatic bscs_result_t advance_sequence(input bscs_poll_t p);
    logic [4:0]           s;
    logic [4:0]           next_s;
    logic [CmdWidth-1:0]  cmd;
    logic                 fail;
    logic                 timed;
    logic [1:0]           want_pres;
    logic [TimeWidth-1:0] waited;
    bscs_result_t         r;
    s = seq_q;
    cmd = '0;
    fail = 1'b0;
    timed = 1'b0;
    want_pres = PRES_RELEASED;
    if (s > ST_WAIT_MISSION && s < ST_COMPLETE) begin
      if (!p.asms_on || !p.auto_mission) begin
        fail = 1'b1;
      end else if (s > ST_WAIT_TSMS) begin
        fail = !p.tsms_on;
      end else if (s == ST_WAIT_TSMS) begin
        fail = !p.relay_out;
      end else if (s > ST_WAIT_RES) begin
        fail = !p.relay_in;
      end
      if (fail) begin
        s = ST_WAIT_MISSION;
        cmd = cmd | CMD_EBS_ARM | CMD_SDC_OPEN;
      end
    end
    next_s = s;
    case (s)
      ST_WAIT_MISSION:   if (p.auto_mission) next_s = ST_WAIT_ASMS;
      ST_WAIT_ASMS:      if (p.asms_on) next_s = ST_ARM_EBS;
      ST_ARM_EBS: begin
        cmd = cmd | CMD_EBS_ARM;
        next_s = ST_WAIT_RES;
      end
      ST_WAIT_RES:       if (p.relay_in) next_s = ST_CLOSE_SDC;
      ST_CLOSE_SDC: begin
        cmd = cmd | CMD_SDC_CLOSE;
        next_s = ST_WAIT_SDC_CLOSE;
      end
      ST_WAIT_SDC_CLOSE: if (p.relay_out) next_s = ST_STOP_WDG;
      ST_STOP_WDG: begin
        cmd = cmd | CMD_WDG_STOP;
        next_s = ST_WAIT_SDC_OPEN;
      end
      ST_WAIT_SDC_OPEN:  if (!p.relay_out) next_s = ST_START_WDG;
      ST_START_WDG: begin
        cmd = cmd | CMD_WDG_START;
        next_s = ST_WAIT_SDC_AGAIN;
      end
      ST_WAIT_SDC_AGAIN: if (p.relay_out) next_s = ST_WAIT_TSMS;
      ST_WAIT_TSMS:      if (p.tsms_on) next_s = ST_RELEASE_EBS;
      ST_RELEASE_EBS: begin
        if (p.ebs_active) cmd = cmd | CMD_EBS_RELEASE | CMD_SVC_DISENG;
        timed = 1'b1;
      end
      ST_ENGAGE_SYS1: begin
        if (!p.system1_on) cmd = cmd | CMD_SYS1_ON;
        timed = 1'b1;
        want_pres = PRES_ENGAGED;
      end
      ST_RELEASE_SYS1: begin
        if (p.system1_on) cmd = cmd | CMD_SYS1_OFF;
        timed = 1'b1;
      end
      ST_ENGAGE_SYS2: begin
        if (!p.system2_on) cmd = cmd | CMD_SYS2_ON;
        timed = 1'b1;
        want_pres = PRES_ENGAGED;
      end
      ST_RELEASE_SYS2: begin
        if (p.system2_on) cmd = cmd | CMD_SYS2_OFF;
        timed = 1'b1;
      end
      ST_ENGAGE_SVC: begin
        if (p.service_status != SVC_ENGAGED) cmd = cmd | CMD_SVC_ENGAGE;
        timed = 1'b1;
        want_pres = PRES_ENGAGED;
      end
      ST_RELEASE_SVC: begin
        if (p.service_status != SVC_DISENGAGED) cmd = cmd | CMD_SVC_DISENG;
        timed = 1'b1;
      end
      ST_PARK_SVC: begin
        cmd = cmd | CMD_SVC_PARK;
        next_s = ST_NOTIFY_APU;
      end
      ST_NOTIFY_APU:     if (p.apu_state == APU_READY) next_s = ST_COMPLETE;
      default: ;
    endcase
    // The timed states sit in sequence order, so each one advances to the next code.
    if (timed) begin
      if (!timer_run_q) begin
        timer_start_q = p.now_ms;
        timer_run_q = 1'b1;
      end
      waited = p.now_ms - timer_start_q;
      if (waited >= TimeWidth'(settle_ms)) begin
        timer_run_q = 1'b0;
        if (p.pressure_level == want_pres) next_s = s + 5'd1;
      end
    end
    seq_q = next_s;
    r.check_state = next_s;
    r.command_mask = cmd;
    r.failed = fail;
    r.notify_apu = (next_s == ST_NOTIFY_APU);
    r.complete = (next_s == ST_COMPLETE);
    return r;
  endfunction

  always @(posedge clk) begin
    bscs_result_t want;
    if (rst) begin
      settle_ms = SettleReset;
      seq_q = ST_WAIT_MISSION;
      timer_start_q = '0;
      timer_run_q = 1'b0;
      predicted_steps.delete();
    end else begin
      if (cfg_write_en) settle_ms = cfg_write_data;
      if (result_valid && result_ready) begin
        if (predicted_steps.size() == 0) begin
          report_mismatch($sformatf("result with no poll waiting, state %0d", check_state));
        end else begin
          want = predicted_steps.pop_front();
          if (check_state !== want.check_state)
            report_mismatch($sformatf("check_state %0d, expected %0d",
                                      check_state, want.check_state));
          if (command_mask !== want.command_mask)
            report_mismatch($sformatf("command_mask %h, expected %h",
                                      command_mask, want.command_mask));
          if (failed !== want.failed)
            report_mismatch($sformatf("failed %b, expected %b", failed, want.failed));
          if (notify_apu !== want.notify_apu)
            report_mismatch($sformatf("notify_apu %b, expected %b",
                                      notify_apu, want.notify_apu));
          if (complete !== want.complete)
            report_mismatch($sformatf("complete %b, expected %b", complete, want.complete));
        end
      end
      if (poll_valid && poll_ready) predicted_steps.push_back(advance_sequence(poll));
    end
    pending = predicted_steps.size();
    model_state = seq_q;
  end

endmodule

>>> sim/brake_system_initial_check_sequencer_test.sv
// Top of the testbench for the brake system initial check sequencer.
// Makes the poll, configuration and back-pressure stimulus and gives the verdict;
// depends on bscs_pkg, the block itself and bscs_step_checker.
`timescale 1ns / 100ps

module brake_system_initial_check_sequencer_test;
  import bscs_pkg::*;

  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned QuietLimit = 2000;

  logic                   clk;
  logic                   rst            = 1'b1;
  logic                   cfg_write_en   = 1'b0;
  logic [SettleWidth-1:0] cfg_write_data = '0;
  logic                   poll_valid     = 1'b0;
  bscs_poll_t             poll_item      = '0;
  logic                   result_ready   = 1'b0;
  logic                   idle_on        = 1'b1;

  logic                   poll_ready;
  logic                   result_valid;
  logic [4:0]             check_state;
  logic [CmdWidth-1:0]    command_mask;
  logic                   failed;
  logic                   notify_apu;
  logic                   complete;

  int unsigned            pending;
  int unsigned            fail_count;
  logic [4:0]             model_state;

  // Stimulus bookkeeping: the millisecond clock handed to the block, the settle time
  // last written, and the number of polls accepted so far.
  logic [TimeWidth-1:0]   clock_ms   = 32'h0000_1000;
  logic [SettleWidth-1:0] settle_now = SettleReset;
  int unsigned            polls_sent = 0;
  int unsigned            quiet_cycles = 0;

  brake_system_initial_check_sequencer DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .poll_valid     (poll_valid),
    .poll_ready     (poll_ready),
    .auto_mission   (poll_item.auto_mission),
    .asms_on        (poll_item.asms_on),
    .tsms_on        (poll_item.tsms_on),
    .relay_in       (poll_item.relay_in),
    .relay_out      (poll_item.relay_out),
    .ebs_active     (poll_item.ebs_active),
    .system1_on     (poll_item.system1_on),
    .system2_on     (poll_item.system2_on),
    .service_status (poll_item.service_status),
    .pressure_level (poll_item.pressure_level),
    .apu_state      (poll_item.apu_state),
    .now_ms         (poll_item.now_ms),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .check_state    (check_state),
    .command_mask   (command_mask),
    .failed         (failed),
    .notify_apu     (notify_apu),
    .complete       (complete)
  );

  bscs_step_checker step_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .poll_valid     (poll_valid),
    .poll_ready     (poll_ready),
    .poll           (poll_item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .check_state    (check_state),
    .command_mask   (command_mask),
    .failed         (failed),
    .notify_apu     (notify_apu),
    .complete       (complete),
    .pending        (pending),
    .fail_count     (fail_count),
    .model_state    (model_state)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The result side stalls in roughly one cycle in five while idling is enabled.
  always @(negedge clk) begin
    result_ready <= !idle_on || ($urandom_range(0, 99) >= 20);
  end

  // Watchdog: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (poll_valid && poll_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("brake_system_initial_check_sequencer_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bscs_poll_t random_poll();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(bscs_poll_t)-1:0];
  endfunction

  // All safety inputs good and the time given; the remaining fields, undefined codes included, stay random.
  function automatic bscs_poll_t healthy_poll(input logic [TimeWidth-1:0] now);
    bscs_poll_t p;
    p = random_poll();
    p.auto_mission = 1'b1;
    p.asms_on = 1'b1;
    p.tsms_on = 1'b1;
    p.relay_in = 1'b1;
    p.relay_out = 1'b1;
    p.now_ms = now;
    return p;
  endfunction

  // Offers one poll item and returns at the falling edge after it has been accepted.
  // It is always entered at a falling edge, so valid and payload change there only.
  task automatic send_poll(input bscs_poll_t p);
    int unsigned gap;
    gap = 0;
    if (idle_on && chance(15)) gap = $urandom_range(1, 2);
    if (gap != 0) begin
      poll_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    poll_valid <= 1'b1;
    poll_item <= p;
    @(posedge clk);
    while (!poll_ready) @(posedge clk);
    @(negedge clk);
    polls_sent++;
  endtask

  // The settle time is only changed once every poll has produced its result, so the
  // block is idle when the write lands.
  task automatic write_settle(input logic [SettleWidth-1:0] value);
    poll_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    settle_now = value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // One attempt at the whole self-test. Each poll is shaped from the state the
  // scoreboard currently predicts, so most polls move the sequence on, while a few
  // break a safety input or are pure noise. Unless finishing, the APU never reports
  // ready in the notify state, since completion is final and only reset leaves it;
  // the attempt then ends with a non-autonomous mission, which drops back to the start.
  task automatic drive_check_walk(input bit finish, input int unsigned budget);
    bscs_poll_t  p;
    logic [4:0]  st;
    int unsigned n;
    int unsigned notify_polls;
    notify_polls = 0;
    for (n = 0; n < budget; n++) begin
      st = model_state;
      if (st == ST_COMPLETE) break;
      if (!finish && st == ST_NOTIFY_APU) begin
        if (notify_polls == 3) break;
        notify_polls++;
      end
      if (chance(2)) begin
        clock_ms = $urandom();
      end else begin
        clock_ms = clock_ms + $urandom_range(0, settle_now / 2 + 1);
      end
      p = healthy_poll(clock_ms);
      case (st)
        ST_WAIT_RES:                        p.relay_in = chance(70);
        ST_WAIT_SDC_CLOSE, ST_WAIT_SDC_AGAIN: p.relay_out = chance(70);
        ST_WAIT_SDC_OPEN:                   p.relay_out = !chance(70);
        ST_WAIT_TSMS:                       p.tsms_on = chance(70);
        ST_RELEASE_EBS, ST_RELEASE_SYS1, ST_RELEASE_SYS2, ST_RELEASE_SVC: begin
          if (chance(75)) p.pressure_level = PRES_RELEASED;
        end
        ST_ENGAGE_SYS1, ST_ENGAGE_SYS2, ST_ENGAGE_SVC: begin
          if (chance(75)) p.pressure_level = PRES_ENGAGED;
        end
        ST_NOTIFY_APU: begin
          if (finish && chance(50)) p.apu_state = APU_READY;
        end
        default: ;
      endcase
      // Occasionally knock out one safety input; whether it trips depends on the state.
      if (chance(4)) begin
        case ($urandom_range(0, 4))
          0:       p.auto_mission = 1'b0;
          1:       p.asms_on = 1'b0;
          2:       p.tsms_on = 1'b0;
          3:       p.relay_in = 1'b0;
          default: p.relay_out = 1'b0;
        endcase
      end
      if (chance(8)) p = random_poll();
      if (!finish && st == ST_NOTIFY_APU && p.apu_state == APU_READY) p.apu_state = 4'd3;
      send_poll(p);
    end
    if (finish) begin
      // Once complete, the state is held whatever the inputs do.
      repeat (3) send_poll(random_poll());
    end else begin
      p = random_poll();
      p.auto_mission = 1'b0;
      send_poll(p);
    end
  endtask

  task automatic run_phase(input logic [SettleWidth-1:0] settle, input bit idle,
                           input int unsigned count);
    int unsigned target;
    int unsigned left;
    write_settle(settle);
    idle_on <= idle;
    target = polls_sent + count;
    while (polls_sent < target) begin
      left = target - polls_sent;
      drive_check_walk(1'b0, (left < 90) ? left : 90);
    end
  endtask

  initial begin
    bscs_poll_t p;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed part, with the settle time still at its reset value of 100 ms.
    // All fields low, then all fields high: the mission is autonomous, so the
    // sequence leaves wait-for-mission.
    p = '0;
    send_poll(p);
    p = '1;
    send_poll(p);
    // ASMS off while waiting for it: a failure, then straight back to wait-ASMS.
    p = healthy_poll(32'd10);
    p.asms_on = 1'b0;
    send_poll(p);
    send_poll(healthy_poll(32'd11));
    send_poll(healthy_poll(32'd12));
    // No RES yet: the sequence waits without failing.
    p = healthy_poll(32'd13);
    p.relay_in = 1'b0;
    send_poll(p);
    send_poll(healthy_poll(32'd14));
    send_poll(healthy_poll(32'd15));
    // Shutdown circuit still open after the close command.
    p = healthy_poll(32'd16);
    p.relay_out = 1'b0;
    send_poll(p);
    send_poll(healthy_poll(32'd17));
    send_poll(healthy_poll(32'd18));
    // The circuit opens after the watchdog stop, then closes again after its start.
    p = healthy_poll(32'd19);
    p.relay_out = 1'b0;
    send_poll(p);
    send_poll(healthy_poll(32'd20));
    send_poll(healthy_poll(32'd21));
    // TSMS still open: the sequence waits for it.
    p = healthy_poll(32'd22);
    p.tsms_on = 1'b0;
    send_poll(p);
    send_poll(healthy_poll(32'd23));
    // EBS release with the settle timer started just short of the time wrap.
    p = healthy_poll(32'hFFFF_FFC0);
    p.ebs_active = 1'b1;
    p.pressure_level = PRES_RELEASED;
    send_poll(p);
    // Exactly 100 ms later across the wrap, but with the wrong pressure: the timer
    // stops and the state stays.
    p = healthy_poll(32'h0000_0024);
    p.pressure_level = PRES_ENGAGED;
    send_poll(p);
    // Timing restarts here and the step advances once the settle time has passed.
    p = healthy_poll(32'h0000_0030);
    p.pressure_level = PRES_RELEASED;
    send_poll(p);
    p = healthy_poll(32'h0000_0094);
    p.pressure_level = PRES_RELEASED;
    send_poll(p);
    // TSMS lost during the brake checks, then a non-autonomous mission.
    p = healthy_poll(32'h0000_0095);
    p.tsms_on = 1'b0;
    send_poll(p);
    p = healthy_poll(32'h0000_0096);
    p.auto_mission = 1'b0;
    send_poll(p);

    // Random part: whole self-test attempts under a range of settle times, including
    // both extremes, and one long stretch with no idling on either side.
    run_phase(16'd0, 1'b1, 200);
    run_phase(16'hFFFF, 1'b1, 200);
    run_phase(16'd1, 1'b1, 200);
    run_phase(SettleWidth'($urandom_range(2, 400)), 1'b1, 200);
    run_phase(SettleReset, 1'b0, 250);
    run_phase(SettleWidth'($urandom_range(0, 65535)), 1'b1, 200);
    run_phase(16'd7, 1'b1, 120);
    // The last attempt is allowed to reach completion.
    drive_check_walk(1'b1, 400);

    poll_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("brake_system_initial_check_sequencer_test: PASS");
    end else begin
      $display("brake_system_initial_check_sequencer_test: FAIL");
    end
    $finish;
  end

endmodule
